// File: src/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define KFD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("kfd assertion failed");

// Clocked check that also runs while reset is held.
`define KFD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("kfd assertion failed");

`endif

// File: src/kfd_pkg.sv
// Package for the KISS frame decoder: item types, KISS codes and action codes.
// Has no dependencies; the top level, kfd_ctrl and the checker import it.
package kfd_pkg;

    // KISS framing codes.
    localparam logic [7:0] KISS_FEND  = 8'hC0;
    localparam logic [7:0] KISS_FESC  = 8'hDB;
    localparam logic [7:0] KISS_TFEND = 8'hDC;
    localparam logic [7:0] KISS_TFESC = 8'hDD;

    // Action codes of an input item.
    localparam logic ACT_FEED = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam int unsigned LEN_W = 10;
    localparam int unsigned IDX_W = 9;

    // One input item.
    typedef struct packed {
        logic             action;
        logic [7:0]       rx_byte;
        logic [IDX_W-1:0] read_index;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic             frame_done;
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       read_data;
    } t_out_item;

    // Frame result of one fed byte, passed from the control unit to the top level.
    typedef struct packed {
        logic             frame_done;
        logic [LEN_W-1:0] frame_length;
    } t_feed_res;

endpackage

// File: src/kiss_frame_decoder_unit.sv
// Top level of the KISS frame decoder: handshake, output register and buffer memory.
// Depends on kfd_pkg, kfd_ctrl and kfd_store.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+-------------------------------
//  input   | i_in_valid  | o_in_ready  | i_in_item  (t_in_item)
//  output  | o_out_valid | i_out_ready | o_out_item (t_out_item)
//
// One item can be accepted each cycle while the output is not stalled.
// Its result appears in the output register the cycle after acceptance;
// a read's byte comes from the buffer's registered read port at that time.
// Reset clears the control state and the output valid; buffer entries are
// undefined until written. A stalled output holds the register and read data,
// and input ready drops only while a result waits and the output is stalled.
module kiss_frame_decoder_unit
    import kfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int unsigned AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int unsigned CW = $clog2(MAX_FRAME + 1);

    logic          fire;
    t_feed_res     feed_res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_hit;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic          r_out_valid;
    t_feed_res     r_res;
    logic          r_rd_hit;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;

    // Reads beyond the buffer answer zero.
    assign rd_hit  = (i_in_item.action == ACT_READ) &&
                     ({23'd0, i_in_item.read_index} < 32'(MAX_FRAME));
    assign rd_en   = fire && rd_hit;
    assign rd_addr = AW'(i_in_item.read_index);

    kfd_ctrl #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (i_in_item),
        .o_res     (feed_res),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    kfd_store #(
        .DEPTH (MAX_FRAME),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res    <= (i_in_item.action == ACT_FEED) ? feed_res : '0;
            r_rd_hit <= rd_hit;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_out_item.frame_done   = r_res.frame_done;
    assign o_out_item.frame_length = r_res.frame_length;
    assign o_out_item.read_data    = r_rd_hit ? rd_data : 8'd0;

endmodule

// File: src/kfd_store.sv
// Frame buffer memory: one write port and one registered read port.
// Depends on no package; depth and address width come from the parameters.
module kfd_store #(
    parameter int unsigned DEPTH = 512,
    parameter int unsigned AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds until the next enabled read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/kfd_ctrl.sv
// Deframing control: sync, escape, overflow and fill state, and buffer write requests.
// Depends on kfd_pkg for the KISS codes, action codes and result type.
module kfd_ctrl
    import kfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 512,
    parameter int unsigned AW        = 9,
    parameter int unsigned CW        = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  t_in_item      i_item,
    output t_feed_res     o_res,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data
);

    logic [CW-1:0] r_fill, n_fill;
    logic          r_synced, n_synced;
    logic          r_esc, n_esc;
    logic          r_ovf, n_ovf;
    logic          r_clear, n_clear;

    logic [CW-1:0] cnt_eff;
    logic          esc_eff;
    logic          ovf_eff;
    logic          store;
    logic [7:0]    store_byte;
    logic          full;

    // A finished frame is dropped by the first feed that follows it.
    assign cnt_eff = r_clear ? '0 : r_fill;
    assign esc_eff = r_clear ? 1'b0 : r_esc;
    assign ovf_eff = r_clear ? 1'b0 : r_ovf;
    assign full    = (cnt_eff >= CW'(MAX_FRAME));

    // Next state of one fed byte.
    always_comb begin
        n_fill     = cnt_eff;
        n_synced   = r_synced;
        n_esc      = esc_eff;
        n_ovf      = ovf_eff;
        n_clear    = 1'b0;
        store      = 1'b0;
        store_byte = i_item.rx_byte;
        o_res      = '0;
        if (i_item.rx_byte == KISS_FEND) begin
            n_synced = 1'b1;
            if (r_synced && (cnt_eff != '0) && !ovf_eff) begin
                n_clear            = 1'b1;
                o_res.frame_done   = 1'b1;
                o_res.frame_length = LEN_W'(cnt_eff);
            end else begin
                n_fill = '0;
                n_esc  = 1'b0;
                n_ovf  = 1'b0;
            end
        end else if (r_synced && !ovf_eff) begin
            if (esc_eff) begin
                n_esc = 1'b0;
                store = 1'b1;
                if (i_item.rx_byte == KISS_TFEND) begin
                    store_byte = KISS_FEND;
                end else if (i_item.rx_byte == KISS_TFESC) begin
                    store_byte = KISS_FESC;
                end
            end else if (i_item.rx_byte == KISS_FESC) begin
                n_esc = 1'b1;
            end else begin
                store = 1'b1;
            end
        end
        // A byte that finds the buffer full marks the frame overflowed.
        if (store) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_fill = cnt_eff + CW'(1);
            end
        end
    end

    assign o_wr_en   = i_fire && (i_item.action == ACT_FEED) && store && !full;
    assign o_wr_addr = cnt_eff[AW-1:0];
    assign o_wr_data = store_byte;

    // State registers change only on a fed byte or on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_synced <= 1'b0;
            r_esc    <= 1'b0;
            r_ovf    <= 1'b0;
            r_clear  <= 1'b0;
        end else if (i_fire && (i_item.action == ACT_FEED)) begin
            r_fill   <= n_fill;
            r_synced <= n_synced;
            r_esc    <= n_esc;
            r_ovf    <= n_ovf;
            r_clear  <= n_clear;
        end
    end

endmodule

// File: src/kfd_checker.sv
// Port-level checks for the KISS frame decoder, bound to its top level.
// Depends on kfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kfd_checker
    import kfd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // Reset empties the output register.
    `KFD_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid)

    // An accepted item shows its result in the next cycle.
    `KFD_ASSERT(a_accept_to_result, i_in_valid && o_in_ready |=> o_out_valid)

    // A completed frame always carries a length.
    `KFD_ASSERT(a_done_has_len,
        o_out_valid && o_out_item.frame_done |-> o_out_item.frame_length != '0)

    // A length is reported only with a completed frame, never with read data.
    `KFD_ASSERT(a_len_only_done,
        o_out_valid && !o_out_item.frame_done |-> o_out_item.frame_length == '0)

    `KFD_ASSERT(a_done_no_data,
        o_out_valid && o_out_item.frame_done |-> o_out_item.read_data == 8'd0)

endmodule

bind kiss_frame_decoder_unit kfd_checker u_kfd_checker (.*);

// File: tb/kiss_frame_decoder_unit_tb.sv
// Self-checking testbench for the KISS frame decoder top level, kiss_frame_decoder_unit.
// Depends on kfd_pkg for the item types, KISS codes and action codes.
// Drives feeds and buffer reads with random idling on both sides and checks every result item.
module kiss_frame_decoder_unit_tb;
    import kfd_pkg::*;

    localparam int unsigned MAX_FRAME = 512;

    // One queued input item; drain holds it back until every expected result has come.
    typedef struct {
        t_in_item item;
        bit       drain;
    } t_pending;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    kiss_frame_decoder_unit #(
        .MAX_FRAME(MAX_FRAME)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // Shadow copy of the decoder state.
    logic [7:0]  shadow_buf [MAX_FRAME];
    int unsigned fill_cnt  = 0;
    bit          in_sync   = 1'b0;
    bit          esc_pend  = 1'b0;
    bit          ovf       = 1'b0;
    bit          clr_pend  = 1'b0;

    t_pending    pending_items [$];
    t_out_item   expected_results [$];

    // Stimulus bookkeeping: entries below safe_limit are known to have been written.
    int unsigned safe_limit      = 0;
    int unsigned bulk_items      = 0;
    bit          drain_next      = 1'b0;
    int unsigned overflow_frames = 0;

    // Handshake pacing and run statistics.
    bit          quiet_phase  = 1'b0;
    bit          in_taken     = 1'b0;
    int unsigned in_gap       = 0;
    int unsigned out_stall    = 0;
    int unsigned error_count  = 0;
    int unsigned frames_done  = 0;
    int unsigned reads_done   = 0;
    int unsigned results_seen = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Wait length for one item; zero throughout a quiet stretch.
    function automatic int unsigned draw_wait();
        return quiet_phase ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic void open_frame();
        fill_cnt = 0;
        esc_pend = 1'b0;
        ovf      = 1'b0;
        clr_pend = 1'b0;
    endfunction

    // Advances the shadow state by one item and returns the result it should produce.
    function automatic t_out_item deframe_step(t_in_item it);
        t_out_item  res;
        logic [7:0] d;
        bit         keep;
        res  = '0;
        d    = it.rx_byte;
        keep = 1'b0;
        if (it.action == ACT_READ) begin
            if (it.read_index < MAX_FRAME) begin
                res.read_data = shadow_buf[it.read_index];
            end
            return res;
        end
        if (clr_pend) begin
            open_frame();
        end
        if (it.rx_byte == KISS_FEND) begin
            if (in_sync && fill_cnt > 0 && !ovf) begin
                clr_pend         = 1'b1;
                res.frame_done   = 1'b1;
                res.frame_length = LEN_W'(fill_cnt);
            end else begin
                open_frame();
            end
            in_sync = 1'b1;
        end else if (in_sync && !ovf) begin
            if (esc_pend) begin
                // Undo the escape; any other byte after FESC goes through as it is.
                esc_pend = 1'b0;
                keep     = 1'b1;
                if (it.rx_byte == KISS_TFEND) begin
                    d = KISS_FEND;
                end else if (it.rx_byte == KISS_TFESC) begin
                    d = KISS_FESC;
                end
            end else if (it.rx_byte == KISS_FESC) begin
                esc_pend = 1'b1;
            end else begin
                keep = 1'b1;
            end
            if (keep) begin
                if (fill_cnt >= MAX_FRAME) begin
                    ovf = 1'b1;
                end else begin
                    shadow_buf[fill_cnt] = d;
                    fill_cnt++;
                end
            end
        end
        return res;
    endfunction

    task automatic push_item(logic act, logic [7:0] b, logic [IDX_W-1:0] idx);
        t_pending p;
        p.item.action     = act;
        p.item.rx_byte    = b;
        p.item.read_index = idx;
        p.drain           = drain_next;
        drain_next        = 1'b0;
        pending_items.push_back(p);
        bulk_items++;
    endtask

    // A feed carries a random index that the block must ignore.
    task automatic push_feed(logic [7:0] b);
        push_item(ACT_FEED, b, IDX_W'($urandom));
    endtask

    // Reads only entries that have been written, leaning toward the ends of that range.
    task automatic push_read();
        logic [IDX_W-1:0] idx;
        if (safe_limit == 0) begin
            return;
        end
        case ($urandom_range(0, 3))
            0: idx = '0;
            1: idx = IDX_W'(safe_limit - 1);
            default: idx = IDX_W'($urandom_range(0, safe_limit - 1));
        endcase
        push_item(ACT_READ, 8'($urandom), idx);
    endtask

    // Encodes one frame of n decoded bytes, with reads mixed in, and closes it with FEND.
    task automatic push_frame(int unsigned n, bit with_open);
        logic [7:0] d;
        if (with_open) begin
            push_feed(KISS_FEND);
        end
        for (int unsigned k = 0; k < n; k++) begin
            case ($urandom_range(0, 19))
                0: d = KISS_FEND;
                1: d = KISS_FESC;
                2: d = KISS_TFEND;
                3: d = KISS_TFESC;
                default: d = 8'($urandom);
            endcase
            if ($urandom_range(0, 19) == 0) begin
                // Malformed escape: the byte after FESC is stored unchanged.
                do begin
                    d = 8'($urandom);
                end while (d == KISS_FEND || d == KISS_TFEND || d == KISS_TFESC);
                push_feed(KISS_FESC);
                push_feed(d);
            end else if (d == KISS_FEND) begin
                push_feed(KISS_FESC);
                push_feed(KISS_TFEND);
            end else if (d == KISS_FESC) begin
                push_feed(KISS_FESC);
                push_feed(KISS_TFESC);
            end else begin
                push_feed(d);
            end
            if (k < MAX_FRAME && k + 1 > safe_limit) begin
                safe_limit = k + 1;
            end
            if ($urandom_range(0, 9) == 0) begin
                push_read();
            end
        end
        push_feed(KISS_FEND);
    endtask

    // Input driver: presents the next queued item once the current one is taken.
    always @(negedge i_clk) begin
        t_pending cur;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            in_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].drain && expected_results.size() > 0)) begin
                cur = pending_items.pop_front();
                i_in_item  <= cur.item;
                i_in_valid <= 1'b1;
                in_gap = draw_wait();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output ready: stalls for a drawn wait after each result item.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Monitor: checks results against the oldest expectation, then predicts accepted inputs.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                out_stall = draw_wait();
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result item with nothing expected, got done=%0b len=%0d data=%0h",
                             $time, o_out_item.frame_done, o_out_item.frame_length,
                             o_out_item.read_data);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.frame_done) begin
                        frames_done++;
                    end
                    if (o_out_item.frame_done !== want.frame_done) begin
                        $display("%0t: frame_done mismatch, expected %0b, got %0b",
                                 $time, want.frame_done, o_out_item.frame_done);
                        error_count++;
                    end
                    if (o_out_item.frame_length !== want.frame_length) begin
                        $display("%0t: frame_length mismatch, expected %0d, got %0d",
                                 $time, want.frame_length, o_out_item.frame_length);
                        error_count++;
                    end
                    if (o_out_item.read_data !== want.read_data) begin
                        $display("%0t: read_data mismatch, expected %0h, got %0h",
                                 $time, want.read_data, o_out_item.read_data);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(deframe_step(i_in_item));
                in_taken = 1'b1;
                if (i_in_item.action == ACT_READ) begin
                    reads_done++;
                end
                // Switch between idling and back-to-back stretches now and then.
                if ($urandom_range(0, 59) == 0) begin
                    quiet_phase = !quiet_phase;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned n;
        int unsigned pick;
        bit          clean;
        bit          ovf_done;
        ovf_done = 1'b0;

        // Directed: bytes before sync, empty frames, every escape form, reads of the frame.
        push_feed(8'h41);
        push_feed(KISS_FESC);
        push_feed(KISS_FEND);
        push_feed(KISS_FEND);
        push_feed(8'h00);
        push_feed(KISS_FESC);
        push_feed(KISS_TFEND);
        push_feed(KISS_FESC);
        push_feed(KISS_TFESC);
        push_feed(KISS_FESC);
        push_feed(8'h55);
        push_feed(8'hFF);
        push_feed(KISS_FEND);
        safe_limit = 5;
        for (int unsigned k = 0; k < 5; k++) begin
            push_item(ACT_READ, (k % 2 == 0) ? 8'h00 : 8'hFF, IDX_W'(k));
        end
        // An escape cut short by FEND still closes the frame; stale entries stay readable.
        push_feed(8'h12);
        push_feed(KISS_FESC);
        push_feed(KISS_FEND);
        push_item(ACT_READ, 8'hFF, IDX_W'(0));
        push_item(ACT_READ, 8'h00, IDX_W'(4));
        clean = 1'b1;

        // Random part: mostly well-formed frames, with reads and line noise mixed in.
        bulk_items = 0;
        drain_next = 1'b1;
        while (bulk_items < 800) begin
            // One frame runs past the end of the buffer: it fills every entry, then overflows.
            if (!ovf_done && bulk_items >= 80) begin
                push_frame(MAX_FRAME + $urandom_range(1, 4), !clean);
                repeat (4) push_read();
                overflow_frames++;
                ovf_done   = 1'b1;
                clean      = 1'b1;
                drain_next = 1'b1;
            end
            if ($urandom_range(0, 49) == 0) begin
                drain_next = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 9))
                    0: n = 0;
                    1: n = $urandom_range(13, 40);
                    default: n = $urandom_range(1, 12);
                endcase
                push_frame(n, !clean || $urandom_range(0, 3) == 0);
                clean = 1'b1;
                repeat ($urandom_range(0, 3)) push_read();
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) push_read();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 7))
                        0: push_feed(KISS_FEND);
                        1: push_feed(KISS_FESC);
                        2: push_feed(KISS_TFEND);
                        3: push_feed(KISS_TFESC);
                        4: begin
                            push_feed(KISS_FESC);
                            push_feed(KISS_FEND);
                        end
                        default: push_feed(8'($urandom));
                    endcase
                end
                clean = 1'b0;
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);

        $display("Checked %0d results: %0d frames closed, %0d buffer reads, %0d overflowed frames.",
                 results_seen, frames_done, reads_done, overflow_frames);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a stuck handshake or a missing result.
    initial begin
        #5000000;
        $display("Run timed out with %0d results still expected.", expected_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/kfd_pkg.sv
src/kfd_store.sv
src/kfd_ctrl.sv
src/kiss_frame_decoder_unit.sv
src/kfd_checker.sv
tb/kiss_frame_decoder_unit_tb.sv
